>>> design/complex_rect_polar_convert_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the complex rectangular/polar converter
// Shared helpers for concurrent checks sampled on clk_i.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_RECT_POLAR_CONVERT_CORE_DEFINES_SVH
`define COMPLEX_RECT_POLAR_CONVERT_CORE_DEFINES_SVH

// Check that is suspended while rst_ni is low.
`define CRPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that also holds while reset is applied.
`define CRPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> design/crpc_pkg.sv
// ----------------------------------------------------------------------------
// crpc_pkg
// Types and constants shared by the rectangular/polar CORDIC converter.
// ----------------------------------------------------------------------------
package crpc_pkg;

  // Coordinate width of the ports and the fraction bits kept inside the rotator.
  localparam int unsigned COORD_WIDTH = 16;
  localparam int unsigned GUARD_BITS  = 8;

  // Rotator datapath: enough headroom for the CORDIC gain on a full-scale vector.
  localparam int unsigned XY_W  = COORD_WIDTH + GUARD_BITS + 4;
  localparam int unsigned ANG_W = 32;

  // Inverse CORDIC gain in Q20 and the final scaling shift.
  localparam int unsigned INV_GAIN_FRAC = 20;
  localparam logic signed [INV_GAIN_FRAC:0] INV_GAIN = 21'sd636751;
  localparam int unsigned SCALE_SHIFT = INV_GAIN_FRAC + GUARD_BITS;
  localparam int unsigned PROD_W = XY_W + INV_GAIN_FRAC + 1;

  // Angle constants in units of pi / 2^31.
  localparam logic [ANG_W-1:0] ANG_PI = {1'b1, {(ANG_W-1){1'b0}}};
  localparam logic [ANG_W-1:0] ANG_HALF_STEP = ANG_W'(1) << (ANG_W - 1 - COORD_WIDTH);

  // Function codes.
  localparam logic FUNC_TO_POLAR = 1'b0;
  localparam logic FUNC_TO_RECT  = 1'b1;

  // Arctangent of 2^-i, truncated, in units of pi / 2^31.
  localparam logic [ANG_W-1:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

  // Input word.
  typedef struct packed {
    logic                          func;
    logic signed [COORD_WIDTH-1:0] coord_a;
    logic signed [COORD_WIDTH-1:0] coord_b;
  } crpc_in_t;

  // Result word.
  typedef struct packed {
    logic signed [COORD_WIDTH:0]   out_first;
    logic signed [COORD_WIDTH-1:0] out_second;
  } crpc_out_t;

  // State carried from cell to cell along the rotator.
  typedef struct packed {
    logic                   func;
    logic                   zero;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [ANG_W-1:0]       z;
  } crpc_rot_t;

endpackage

>>> design/crpc_pre.sv
// ----------------------------------------------------------------------------
// crpc_pre
// Input stage: scales the coordinates and pre-rotates into the right half plane.
// ----------------------------------------------------------------------------
module crpc_pre (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  crpc_pkg::crpc_in_t  word_i,
  output logic                valid_o,
  output crpc_pkg::crpc_rot_t rot_o
);
  import crpc_pkg::*;

  logic signed [XY_W-1:0] a_ext;
  logic signed [XY_W-1:0] b_ext;
  logic [ANG_W-1:0]       ang_in;
  crpc_rot_t              rot_d;
  crpc_rot_t              rot_q;
  logic                   valid_q;

  // Sign extend and append the guard fraction bits.
  assign a_ext = {{(XY_W-COORD_WIDTH-GUARD_BITS){word_i.coord_a[COORD_WIDTH-1]}},
                  word_i.coord_a, {GUARD_BITS{1'b0}}};
  assign b_ext = {{(XY_W-COORD_WIDTH-GUARD_BITS){word_i.coord_b[COORD_WIDTH-1]}},
                  word_i.coord_b, {GUARD_BITS{1'b0}}};
  assign ang_in = {word_i.coord_b, {(ANG_W-COORD_WIDTH){1'b0}}};

  // Pre-rotation by pi where the vector or the angle lies in the left half plane.
  always_comb begin
    rot_d.func = word_i.func;
    rot_d.zero = 1'b0;
    rot_d.x    = a_ext;
    rot_d.y    = b_ext;
    rot_d.z    = '0;
    if (word_i.func == FUNC_TO_POLAR) begin
      rot_d.zero = (word_i.coord_a == '0) && (word_i.coord_b == '0);
      if (word_i.coord_a[COORD_WIDTH-1]) begin
        rot_d.x = -a_ext;
        rot_d.y = -b_ext;
        rot_d.z = ANG_PI;
      end
    end else begin
      rot_d.y = '0;
      rot_d.z = ang_in;
      // Angle in [pi/2, 3pi/2): negate the magnitude and turn the angle by pi.
      if (ang_in[ANG_W-1] ^ ang_in[ANG_W-2]) begin
        rot_d.x = -a_ext;
        rot_d.z = ang_in ^ ANG_PI;
      end
    end
  end

  // Stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
    end
  end

  assign valid_o = valid_q;
  assign rot_o   = rot_q;

endmodule

>>> design/crpc_cell.sv
// ----------------------------------------------------------------------------
// crpc_cell
// One CORDIC micro-rotation by atan(2^-SHIFT), registered.
// ----------------------------------------------------------------------------
module crpc_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  crpc_pkg::crpc_rot_t rot_i,
  output logic                valid_o,
  output crpc_pkg::crpc_rot_t rot_o
);
  import crpc_pkg::*;

  localparam logic [ANG_W-1:0] ATAN = ATAN_TAB[SHIFT];

  logic signed [XY_W-1:0] x_in;
  logic signed [XY_W-1:0] y_in;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic                   ccw;
  crpc_rot_t              rot_d;
  crpc_rot_t              rot_q;
  logic                   valid_q;

  assign x_in = rot_i.x;
  assign y_in = rot_i.y;
  assign dx   = y_in >>> SHIFT;
  assign dy   = x_in >>> SHIFT;

  // Vectoring drives y toward zero, rotation drives the residual angle to zero.
  assign ccw = (rot_i.func == FUNC_TO_RECT) ? !rot_i.z[ANG_W-1] : y_in[XY_W-1];

  always_comb begin
    rot_d = rot_i;
    if (ccw) begin
      rot_d.x = x_in - dx;
      rot_d.y = y_in + dy;
      rot_d.z = rot_i.z - ATAN;
    end else begin
      rot_d.x = x_in + dx;
      rot_d.y = y_in - dy;
      rot_d.z = rot_i.z + ATAN;
    end
  end

  // Stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
    end
  end

  assign valid_o = valid_q;
  assign rot_o   = rot_q;

endmodule

>>> design/crpc_post.sv
// ----------------------------------------------------------------------------
// crpc_post
// Gain removal: registered multiply, then rounding, saturation and angle round.
// ----------------------------------------------------------------------------
module crpc_post (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  crpc_pkg::crpc_rot_t rot_i,
  output logic                valid_o,
  output crpc_pkg::crpc_out_t word_o
);
  import crpc_pkg::*;

  localparam int unsigned RND_W = PROD_W - SCALE_SHIFT;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (SCALE_SHIFT - 1);
  localparam logic signed [RND_W-1:0] FIRST_MAX  = RND_W'((2 ** COORD_WIDTH) - 1);
  localparam logic signed [RND_W-1:0] FIRST_MIN  = RND_W'(-(2 ** COORD_WIDTH));
  localparam logic signed [RND_W-1:0] SECOND_MAX = RND_W'((2 ** (COORD_WIDTH - 1)) - 1);
  localparam logic signed [RND_W-1:0] SECOND_MIN = RND_W'(-(2 ** (COORD_WIDTH - 1)));

  logic signed [PROD_W-1:0] prod_x_d;
  logic signed [PROD_W-1:0] prod_y_d;
  logic signed [PROD_W-1:0] prod_x_q;
  logic signed [PROD_W-1:0] prod_y_q;
  logic [ANG_W-1:0]         z_q;
  logic                     func_q;
  logic                     zero_q;
  logic                     valid_q;
  logic signed [PROD_W-1:0] sum_x;
  logic signed [PROD_W-1:0] sum_y;
  logic signed [RND_W-1:0]  rnd_x;
  logic signed [RND_W-1:0]  rnd_y;
  logic signed [RND_W-1:0]  first_lo;
  logic signed [RND_W-1:0]  first_sat;
  logic signed [RND_W-1:0]  second_sat;
  logic [ANG_W-1:0]         ang_rnd;

  // Multiply by the inverse gain.
  assign prod_x_d = rot_i.x * INV_GAIN;
  assign prod_y_d = rot_i.y * INV_GAIN;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      z_q      <= rot_i.z;
      func_q   <= rot_i.func;
      zero_q   <= rot_i.zero;
    end
  end

  // Round half up, then drop the fraction.
  assign sum_x = prod_x_q + ROUND_HALF;
  assign sum_y = prod_y_q + ROUND_HALF;
  assign rnd_x = sum_x[PROD_W-1:SCALE_SHIFT];
  assign rnd_y = sum_y[PROD_W-1:SCALE_SHIFT];

  // Saturation; the magnitude never goes below zero.
  assign first_lo = (func_q == FUNC_TO_POLAR) ? '0 : FIRST_MIN;

  always_comb begin
    if (rnd_x < first_lo) begin
      first_sat = first_lo;
    end else if (rnd_x > FIRST_MAX) begin
      first_sat = FIRST_MAX;
    end else begin
      first_sat = rnd_x;
    end
    if (rnd_y < SECOND_MIN) begin
      second_sat = SECOND_MIN;
    end else if (rnd_y > SECOND_MAX) begin
      second_sat = SECOND_MAX;
    end else begin
      second_sat = rnd_y;
    end
  end

  // Angle rounded to the output step; +pi wraps to -pi.
  assign ang_rnd = z_q + ANG_HALF_STEP;

  always_comb begin
    word_o.out_first  = first_sat[COORD_WIDTH:0];
    word_o.out_second = second_sat[COORD_WIDTH-1:0];
    if (func_q == FUNC_TO_POLAR) begin
      word_o.out_second = ang_rnd[ANG_W-1 -: COORD_WIDTH];
      if (zero_q) begin
        word_o.out_first  = '0;
        word_o.out_second = '0;
      end
    end
  end

  assign valid_o = valid_q;

endmodule

>>> design/complex_rect_polar_convert_core.sv
// ----------------------------------------------------------------------------
// complex_rect_polar_convert_core
// Pipelined CORDIC converter between rectangular and polar complex numbers.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (func, coord_a, coord_b) arrive on in_valid_i/in_ready_o and
//   result words (out_first, out_second) leave on out_valid_o/out_ready_i.
//   func 0 turns (real, imag) into (magnitude, angle); func 1 turns
//   (magnitude, angle) into (real, imag). Angles are in units of pi/32768.
//   On its way to out_valid_o each word passes one pre-rotation stage,
//   one cell per micro-rotation, one multiply stage for the gain, and the
//   output register. It takes one word per cycle while in_ready_o is high.
//   Reset empties the pipeline and the output registers; in_ready_o is high
//   right after reset. When the receiver stalls, the output register holds
//   its word and a second word lands in a skid register; with the skid
//   register full, in_ready_o falls and the whole pipeline holds. in_ready_o
//   comes from a flip-flop and does not depend on out_ready_i in that cycle.
// ----------------------------------------------------------------------------
module complex_rect_polar_convert_core #(
  parameter int unsigned ITERATIONS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  crpc_pkg::crpc_in_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output crpc_pkg::crpc_out_t out_word_o
);
  import crpc_pkg::*;

  logic      en;
  logic      stage_valid [ITERATIONS+1];
  crpc_rot_t stage_rot   [ITERATIONS+1];
  logic      post_valid;
  crpc_out_t post_word;
  logic      incoming;
  logic      pop;
  logic      out_valid_q;
  logic      skid_full_q;
  crpc_out_t out_word_q;
  crpc_out_t skid_word_q;

  // The pipeline moves whenever the skid register has room.
  assign en = !skid_full_q;

  crpc_pre u_pre (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .word_i  (in_word_i),
    .valid_o (stage_valid[0]),
    .rot_o   (stage_rot[0])
  );

  // Chain of micro-rotation cells.
  for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
    crpc_cell #(
      .SHIFT (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (stage_valid[k]),
      .rot_i   (stage_rot[k]),
      .valid_o (stage_valid[k+1]),
      .rot_o   (stage_rot[k+1])
    );
  end

  crpc_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (stage_valid[ITERATIONS]),
    .rot_i   (stage_rot[ITERATIONS]),
    .valid_o (post_valid),
    .word_o  (post_word)
  );

  assign incoming = en && post_valid;
  assign pop      = out_valid_q && out_ready_i;

  // Output and skid occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (pop) begin
        skid_full_q <= 1'b0;
      end
    end else if (incoming) begin
      if (out_valid_q && !pop) begin
        skid_full_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output and skid words.
  always_ff @(posedge clk_i) begin
    if (skid_full_q) begin
      if (pop) begin
        out_word_q <= skid_word_q;
      end
    end else if (incoming) begin
      if (out_valid_q && !pop) begin
        skid_word_q <= post_word;
      end else begin
        out_word_q <= post_word;
      end
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

>>> design/crpc_checker.sv
// ----------------------------------------------------------------------------
// crpc_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "complex_rect_polar_convert_core_defines.svh"

module crpc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input crpc_pkg::crpc_in_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input crpc_pkg::crpc_out_t out_word_o
);

  // A clock edge with reset applied leaves no result word offered.
  `CRPC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "out_valid_o high after reset")

  // A stalled input word holds until it is taken.
  `CRPC_ASSERT(a_in_hold, in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_word_i), "stalled input word changed")

  // A stalled result word holds until it is taken.
  `CRPC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o), "stalled result word changed")

  // Back-pressure only appears with a result word waiting.
  `CRPC_ASSERT(a_stall_has_word, !in_ready_o |-> out_valid_o, "in_ready_o low with no result word pending")

  // The input side is ready in the cycle after the receiver was ready.
  `CRPC_ASSERT(a_ready_recovers, $past(out_ready_i) |-> in_ready_o, "in_ready_o low after receiver took a word")

endmodule

bind complex_rect_polar_convert_core crpc_checker u_crpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

>>> tb/complex_rect_polar_convert_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_rect_polar_convert_core_tb
// Drives conversion words both ways through the CORDIC converter and checks
// every result word against a bit-accurate predictor or a typed-in result.
// A short table of edge cases comes first, then random words, with random
// idling on both sides and one long receiver stall backing up the pipeline.
// ----------------------------------------------------------------------------
module complex_rect_polar_convert_core_tb;
  import crpc_pkg::*;

  // Run length and timing limits, in words and clock cycles.
  localparam int N_DIRECTED = 22;
  localparam int N_WORDS    = N_DIRECTED + 1250;
  localparam int DRAIN      = 40;
  localparam int LIMIT      = 200000;
  localparam int STALL_LEN  = 200;

  // Rotator settings of the design under test.
  localparam int     N_ROT     = 16;
  localparam int     FRAC_BITS = 8;
  localparam longint GAIN_COMP = 636751;

  // Arctangent of 2^-i in units of pi / 2^31, truncated.
  localparam logic [31:0] ARCTAN [N_ROT] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
  };

  // One row of the directed table; known is set where the result is typed in.
  typedef struct packed {
    logic                          func;
    logic signed [COORD_WIDTH-1:0] coord_a;
    logic signed [COORD_WIDTH-1:0] coord_b;
    logic                          known;
    logic signed [COORD_WIDTH:0]   out_first;
    logic signed [COORD_WIDTH-1:0] out_second;
  } edge_row_t;

  localparam edge_row_t EDGE_ROWS [N_DIRECTED] = '{
    // Zero vector gives zero magnitude and zero angle.
    '{FUNC_TO_POLAR,      0,      0, 1'b1, 0, 0},
    '{FUNC_TO_POLAR,  32767,      0, 1'b0, 0, 0},
    // Negative real axis: the angle wraps from +pi to -pi.
    '{FUNC_TO_POLAR, -32768,      0, 1'b0, 0, 0},
    '{FUNC_TO_POLAR,      0,  32767, 1'b0, 0, 0},
    '{FUNC_TO_POLAR,      0, -32768, 1'b0, 0, 0},
    '{FUNC_TO_POLAR, -32768, -32768, 1'b0, 0, 0},
    '{FUNC_TO_POLAR,  32767,  32767, 1'b0, 0, 0},
    '{FUNC_TO_POLAR,     -1,      0, 1'b0, 0, 0},
    '{FUNC_TO_POLAR,     -1,      1, 1'b0, 0, 0},
    '{FUNC_TO_POLAR,     -1,     -1, 1'b0, 0, 0},
    '{FUNC_TO_POLAR,      1,      0, 1'b0, 0, 0},
    '{FUNC_TO_POLAR,      0,      1, 1'b0, 0, 0},
    // Zero magnitude stays zero at any angle.
    '{FUNC_TO_RECT,       0,  12345, 1'b1, 0, 0},
    '{FUNC_TO_RECT,   32767,      0, 1'b0, 0, 0},
    '{FUNC_TO_RECT,   32767, -32768, 1'b0, 0, 0},
    // Angles on both sides of the quadrant folding boundaries.
    '{FUNC_TO_RECT,   32767,  16384, 1'b0, 0, 0},
    '{FUNC_TO_RECT,   32767,  16383, 1'b0, 0, 0},
    '{FUNC_TO_RECT,   32767, -16384, 1'b0, 0, 0},
    '{FUNC_TO_RECT,   32767, -16385, 1'b0, 0, 0},
    // Negative magnitude, including the case that saturates.
    '{FUNC_TO_RECT,  -32768,  16384, 1'b0, 0, 0},
    '{FUNC_TO_RECT,  -32768,      0, 1'b0, 0, 0},
    '{FUNC_TO_RECT,      -1,  32767, 1'b0, 0, 0}
  };

  // Values that sit on field extremes and quadrant boundaries.
  localparam int EDGE_VALS [10] = '{
    -32768, -32767, -16385, -16384, -1, 0, 1, 16383, 16384, 32767
  };

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  crpc_in_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  crpc_out_t out_word_o;

  crpc_out_t expected_words [$];
  int        words_queued  = 0;
  int        words_sent    = 0;
  int        words_checked = 0;
  int        mismatches    = 0;
  int        cycles        = 0;

  complex_rect_polar_convert_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  // Remove the CORDIC gain and the guard bits, rounding half up.
  function automatic longint remove_gain(longint v);
    return (v * GAIN_COMP + (longint'(1) <<< (19 + FRAC_BITS))) >>> (20 + FRAC_BITS);
  endfunction

  function automatic longint saturate(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Bit-accurate conversion of one input word in either direction.
  function automatic crpc_out_t cordic_convert(crpc_in_t w);
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    longint      first;
    longint      second;
    logic [31:0] ang;
    crpc_out_t   res;
    x = longint'($signed(w.coord_a)) * (longint'(1) <<< FRAC_BITS);
    if (w.func == FUNC_TO_POLAR) begin
      y = longint'($signed(w.coord_b)) * (longint'(1) <<< FRAC_BITS);
      ang = '0;
      if (w.coord_a == 0 && w.coord_b == 0) begin
        first = 0;
        second = 0;
      end else begin
        // Left half plane: rotate by pi first.
        if (x < 0) begin
          x = -x;
          y = -y;
          ang = ANG_PI;
        end
        for (int i = 0; i < N_ROT; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (y >= 0) begin
            x += dx;
            y -= dy;
            ang += ARCTAN[i];
          end else begin
            x -= dx;
            y += dy;
            ang -= ARCTAN[i];
          end
        end
        first = saturate(remove_gain(x), 0, 65535);
        // Round to the output angle step; +pi wraps to -pi.
        ang = ang + 32'h0000_8000;
        second = longint'($signed(ang[31:16]));
      end
    end else begin
      ang = {w.coord_b, 16'h0000};
      y = 0;
      // Fold angles outside [-pi/2, pi/2) by negating the magnitude.
      if (ang >= 32'h4000_0000 && ang < 32'hC000_0000) begin
        x = -x;
        ang = ang - ANG_PI;
      end
      z = longint'($signed(ang));
      for (int i = 0; i < N_ROT; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= longint'(ARCTAN[i]);
        end else begin
          x += dx;
          y -= dy;
          z += longint'(ARCTAN[i]);
        end
      end
      first = saturate(remove_gain(x), -65536, 65535);
      second = saturate(remove_gain(y), -32768, 32767);
    end
    res.out_first = first[COORD_WIDTH:0];
    res.out_second = second[COORD_WIDTH-1:0];
    return res;
  endfunction

  // Input word number n: the directed table first, then random words.
  function automatic crpc_in_t make_word(int n);
    crpc_in_t w;
    int       pick;
    if (n < N_DIRECTED) begin
      w.func = EDGE_ROWS[n].func;
      w.coord_a = EDGE_ROWS[n].coord_a;
      w.coord_b = EDGE_ROWS[n].coord_b;
    end else begin
      pick = $urandom_range(9);
      w.func = $urandom_range(1) ? FUNC_TO_RECT : FUNC_TO_POLAR;
      if (pick < 2) begin
        // Tiny vectors reach the zero vector and the axes often.
        w.coord_a = 16'($urandom_range(6)) - 16'sd3;
        w.coord_b = 16'($urandom_range(6)) - 16'sd3;
      end else if (pick == 2) begin
        w.coord_a = 16'(EDGE_VALS[$urandom_range(9)]);
        w.coord_b = 16'(EDGE_VALS[$urandom_range(9)]);
      end else begin
        w.coord_a = 16'($urandom);
        w.coord_b = 16'($urandom);
      end
    end
    return w;
  endfunction

  // Clock with a 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Reset applied from time zero and released once.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Sender: offers words with random idling and keeps a word steady
  // until it is accepted.
  initial begin
    int  gap_left;
    bit  calm;
    gap_left = 0;
    wait (rst_ni);
    while (words_sent < N_WORDS) begin
      @(posedge clk_i);
      if (in_valid_i && in_ready_o) begin
        if (words_sent < N_DIRECTED && EDGE_ROWS[words_sent].known) begin
          expected_words.push_back({EDGE_ROWS[words_sent].out_first,
                                    EDGE_ROWS[words_sent].out_second});
        end else begin
          expected_words.push_back(cordic_convert(in_word_i));
        end
        words_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        calm = words_queued >= 500 && words_queued < 750;
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (words_queued < N_WORDS && (calm || $urandom_range(99) >= 32)) begin
          in_valid_i <= 1'b1;
          in_word_i <= make_word(words_queued);
          words_queued++;
        end else begin
          in_valid_i <= 1'b0;
          // Now and then a gap that can be long enough to drain the pipeline.
          if (!calm && $urandom_range(63) == 0) gap_left = $urandom_range(24, 2);
        end
      end
    end
  end

  // Receiver: checks each result word and stalls at random, once for long.
  initial begin
    crpc_out_t want;
    int        hold_left;
    bit        held;
    bit        calm;
    hold_left = 0;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: result word with none expected: out_first %0d out_second %0d",
                   $time, out_word_o.out_first, out_word_o.out_second);
        end else begin
          want = expected_words.pop_front();
          if (out_word_o.out_first !== want.out_first) begin
            mismatches++;
            $display("%0t: word %0d out_first expected %0d, got %0d", $time,
                     words_checked, want.out_first, out_word_o.out_first);
          end
          if (out_word_o.out_second !== want.out_second) begin
            mismatches++;
            $display("%0t: word %0d out_second expected %0d, got %0d", $time,
                     words_checked, want.out_second, out_word_o.out_second);
          end
        end
        words_checked++;
      end
      calm = words_checked >= 600 && words_checked < 850;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!held && words_checked >= 300) begin
        // Long stall so that the pipeline fills and input ready drops.
        held = 1'b1;
        hold_left = STALL_LEN;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 32);
      end
    end
  end

  // End of run: wait for all results, let the pipeline drain, then report.
  initial begin
    wait (rst_ni);
    while (words_sent < N_WORDS || expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("complex_rect_polar_convert_core_tb: done, clean");
    end else begin
      $display("complex_rect_polar_convert_core_tb: done, errors");
    end
    $finish;
  end

  // Watchdog on the total run length.
  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("complex_rect_polar_convert_core_tb: done, errors");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/crpc_pkg.sv
design/crpc_pre.sv
design/crpc_cell.sv
design/crpc_post.sv
design/complex_rect_polar_convert_core.sv
design/crpc_checker.sv
tb/complex_rect_polar_convert_core_tb.sv
